### src/reliable_transport_conn_engine_core_macros.svh
// Assertion macros for the connection engine checkers.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef RELIABLE_TRANSPORT_CONN_ENGINE_CORE_MACROS_SVH
`define RELIABLE_TRANSPORT_CONN_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define RTCE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rtce_pkg.sv
`timescale 1ns / 1ps

package rtce_pkg;

  typedef enum logic [3:0] {
    ST_ESTABLISHED = 4'd0,
    ST_CLOSED      = 4'd1,
    ST_CLOSE_WAIT  = 4'd2,
    ST_CLOSING     = 4'd3,
    ST_FIN_WAIT_1  = 4'd7,
    ST_FIN_WAIT_2  = 4'd8,
    ST_LAST_ACK    = 4'd9
  } rtce_state_t;

  localparam logic [1:0] CFG_WINDOW_SIZE     = 2'd0;
  localparam logic [1:0] CFG_LOCAL_START_SEQ = 2'd1;
  localparam logic [1:0] CFG_PEER_START_SEQ  = 2'd2;

  localparam logic [15:0] RST_WINDOW_SIZE     = 16'd3072;
  localparam logic [31:0] RST_LOCAL_START_SEQ = 32'd2;
  localparam logic [31:0] RST_PEER_START_SEQ  = 32'd2;

  typedef struct packed {
    logic       seg_present;
    logic       seg_ack_flag;
    logic       seg_fin_flag;
    logic [31:0] seg_ack_num;
    logic [9:0] seg_payload_len;
    logic       app_data_ready;
    logic [9:0] app_bytes_avail;
    logic       close_request;
  } rtce_in_t;

  typedef struct packed {
    logic       send_valid;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic       out_fin;
    logic [9:0] out_payload_len;
    logic [9:0] deliver_len;
    logic       fin_notify;
    logic [3:0] conn_state;
    logic       conn_done;
    logic       last;
  } rtce_out_t;

  typedef struct packed {
    rtce_state_t state;
    logic [31:0] snd_next;
    logic [31:0] snd_acked;
    logic [31:0] rcv_next;
    logic [15:0] credit;
    logic        finished;
  } rtce_conn_t;

  typedef struct packed {
    logic      two;
    rtce_out_t r0;
    rtce_out_t r1;
  } rtce_res_t;

endpackage

### src/rtce_step.sv
`timescale 1ns / 1ps

module rtce_step import rtce_pkg::*; #(
  parameter int MAX_SEG_BYTES = 536
) (
  input  rtce_conn_t cur,
  input  rtce_in_t   item,
  output rtce_conn_t nxt,
  output rtce_res_t  res
);

  localparam logic [15:0] MaxSeg = 16'(MAX_SEG_BYTES);

  logic        drop;
  logic        tx_due;
  logic        notify;
  logic [9:0]  deliver;
  logic [15:0] cap;
  logic [9:0]  take;
  logic        close_ok;
  logic [31:0] fin_seq;
  rtce_out_t   data_res;
  rtce_out_t   fin_res;
  rtce_out_t   stat_res;

  always_comb begin
    nxt      = cur;
    drop     = 1'b0;
    tx_due   = 1'b0;
    notify   = 1'b0;
    deliver  = '0;
    take     = '0;
    cap      = '0;
    close_ok = 1'b0;
    fin_seq  = cur.snd_next;

    if (cur.finished) begin
      drop = 1'b1;
    end else if (item.seg_present) begin
      if (!item.seg_ack_flag) begin
        drop = 1'b1;
      end else begin
        nxt.credit    = cur.credit + 16'(item.seg_ack_num - cur.snd_acked);
        nxt.snd_acked = item.seg_ack_num;
        if (cur.state == ST_LAST_ACK && item.seg_ack_num == cur.snd_next) begin
          nxt.finished = 1'b1;
          nxt.state    = ST_CLOSED;
          drop         = 1'b1;
        end else begin
          deliver      = item.seg_payload_len;
          nxt.rcv_next = cur.rcv_next + {22'd0, item.seg_payload_len}
                         + {31'd0, item.seg_fin_flag};
          if (item.seg_payload_len != 10'd0) begin
            tx_due = 1'b1;
          end
          if (item.seg_fin_flag) begin
            notify = 1'b1;
            tx_due = 1'b1;
            case (cur.state)
              ST_ESTABLISHED: nxt.state = ST_CLOSE_WAIT;
              ST_FIN_WAIT_1: begin
                if (cur.snd_next == item.seg_ack_num) begin
                  nxt.state    = ST_CLOSED;
                  nxt.finished = 1'b1;
                end else begin
                  nxt.state = ST_CLOSING;
                end
              end
              ST_FIN_WAIT_2: begin
                nxt.state    = ST_CLOSED;
                nxt.finished = 1'b1;
              end
              default: nxt.state = cur.state;
            endcase
          end else if (cur.snd_next == item.seg_ack_num) begin
            case (cur.state)
              ST_FIN_WAIT_1: nxt.state = ST_FIN_WAIT_2;
              ST_CLOSING: begin
                nxt.state    = ST_CLOSED;
                nxt.finished = 1'b1;
              end
              default: nxt.state = cur.state;
            endcase
          end
        end
      end
    end

    if (!drop) begin
      if (nxt.credit != 16'd0 && item.app_data_ready) begin
        cap    = (nxt.credit > MaxSeg) ? MaxSeg : nxt.credit;
        take   = (cap > {6'd0, item.app_bytes_avail}) ? item.app_bytes_avail : cap[9:0];
        tx_due = 1'b1;
      end
      if (tx_due) begin
        fin_seq    = cur.snd_next + {22'd0, take};
        nxt.credit = nxt.credit - {6'd0, take};
      end
      close_ok = item.close_request &&
                 (nxt.state == ST_ESTABLISHED || nxt.state == ST_CLOSE_WAIT);
      nxt.snd_next = fin_seq + {31'd0, close_ok};
      if (close_ok) begin
        nxt.state  = (nxt.state == ST_CLOSE_WAIT) ? ST_LAST_ACK : ST_FIN_WAIT_1;
        nxt.credit = nxt.credit - 16'd1;
      end
    end
  end

  always_comb begin
    stat_res             = '0;
    stat_res.deliver_len = deliver;
    stat_res.fin_notify  = notify;
    stat_res.conn_state  = 4'(nxt.state);
    stat_res.conn_done   = nxt.finished;
    stat_res.last        = 1'b1;

    data_res                 = stat_res;
    data_res.send_valid      = 1'b1;
    data_res.out_seq         = cur.snd_next;
    data_res.out_ack         = nxt.rcv_next;
    data_res.out_payload_len = take;
    data_res.last            = !close_ok;

    fin_res            = stat_res;
    fin_res.send_valid = 1'b1;
    fin_res.out_seq    = fin_seq;
    fin_res.out_ack    = nxt.rcv_next;
    fin_res.out_fin    = 1'b1;

    res.two = tx_due && close_ok;
    res.r1  = fin_res;
    if (tx_due) begin
      res.r0 = data_res;
    end else if (close_ok) begin
      res.r0 = fin_res;
    end else begin
      res.r0 = stat_res;
    end
  end

endmodule

### src/rtce_out_q.sv
`timescale 1ns / 1ps

module rtce_out_q import rtce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rtce_res_t push_res,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output rtce_out_t out_data
);

  logic [1:0] count_r;
  logic [1:0] count_nxt;
  rtce_out_t  slot0_r;
  rtce_out_t  slot1_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot0_r;
  assign can_push  = (count_r == 2'd0) || (count_r == 2'd1 && out_ready);

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = push_res.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0_r <= push_res.r0;
      slot1_r <= push_res.r1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

### src/reliable_transport_conn_engine_core.sv
`timescale 1ns / 1ps
// Channel   Ports                           Carries
// in        in_valid / in_ready / in_data   one event item (rtce_in_t)
// out       out_valid / out_ready / out_data one result (rtce_out_t)
// cfg       cfg_wr_en / cfg_addr / cfg_wdata start window and sequence numbers
//
// An item is registered in the input register, then the connection update
// runs combinationally into a two-entry result buffer.
// One item per cycle when each item gives one result and out_ready stays high;
// an item that sends both a data segment and a FIN gives two results, data first.
// Synchronous reset loads the start values; a config write reseeds the window or a start sequence number.
// Stalls on out_ready back up through the buffer into in_ready.

module reliable_transport_conn_engine_core import rtce_pkg::*; #(
  parameter int MAX_SEG_BYTES = 536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rtce_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rtce_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic       in_valid_r;
  rtce_in_t   in_item_r;
  rtce_conn_t conn_r;
  rtce_conn_t conn_nxt;
  rtce_conn_t step_conn;
  rtce_res_t  step_res;
  logic       can_push;
  logic       step_fire;

  assign step_fire = in_valid_r && can_push;
  assign in_ready  = !in_valid_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  rtce_step #(
    .MAX_SEG_BYTES(MAX_SEG_BYTES)
  ) u_step (
    .cur  (conn_r),
    .item (in_item_r),
    .nxt  (step_conn),
    .res  (step_res)
  );

  always_comb begin
    conn_nxt = conn_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_WINDOW_SIZE: conn_nxt.credit = cfg_wdata[15:0];
        CFG_LOCAL_START_SEQ: begin
          conn_nxt.snd_next  = cfg_wdata;
          conn_nxt.snd_acked = cfg_wdata;
        end
        CFG_PEER_START_SEQ: conn_nxt.rcv_next = cfg_wdata;
        default: conn_nxt = conn_r;
      endcase
    end else if (step_fire) begin
      conn_nxt = step_conn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r.state     <= ST_ESTABLISHED;
      conn_r.snd_next  <= RST_LOCAL_START_SEQ;
      conn_r.snd_acked <= RST_LOCAL_START_SEQ;
      conn_r.rcv_next  <= RST_PEER_START_SEQ;
      conn_r.credit    <= RST_WINDOW_SIZE;
      conn_r.finished  <= 1'b0;
    end else begin
      conn_r <= conn_nxt;
    end
  end

  rtce_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_fire),
    .push_res  (step_res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### src/rtce_checker.sv
`timescale 1ns / 1ps
`include "reliable_transport_conn_engine_core_macros.svh"

module rtce_checker import rtce_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input rtce_out_t out_data
);

  `RTCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `RTCE_ASSERT_NEXT(a_second_follows, out_valid && out_ready && !out_data.last, out_valid, "second result of an item not ready next cycle")
  `RTCE_ASSERT_IMPLY(a_fin_last, out_valid && out_data.out_fin, out_data.send_valid && out_data.last && out_data.out_payload_len == 10'd0, "FIN segment malformed")
  `RTCE_ASSERT_IMPLY(a_done_closed, out_valid && out_data.conn_done, out_data.conn_state == 4'(ST_CLOSED), "finished connection not closed")

endmodule

bind reliable_transport_conn_engine_core rtce_checker u_rtce_checker (.*);
